// File: src/md5_pkg.sv
// MD5 digest shared definitions: sequencer states, round-unit control,
// round constants, rotate amounts and message word order. No dependencies.
package md5_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned RoundW  = 6;
    localparam int unsigned PosW    = 6;
    localparam int unsigned WordIdxW = 4;
    localparam int unsigned LenW    = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [PosW-1:0] POS_LAST = 6'd63;
    localparam logic [PosW-1:0] POS_LEN  = 6'd56;
    localparam logic [RoundW-1:0] ROUND_LAST = 6'd63;

    typedef logic [3:0][WordW-1:0] word_quad_t;

    localparam word_quad_t MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_FIN
    } md5_state_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [RoundW-1:0] round;
    } md5_rnd_ctl_t;

    function automatic logic [WordW-1:0] md5_k(input logic [RoundW-1:0] r);
        logic [WordW-1:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [RoundW-1:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [WordIdxW-1:0] md5_word_idx(input logic [RoundW-1:0] r);
        logic [7:0] prod;
        case (r[5:4])
            2'd0:    prod = {2'b00, r};
            2'd1:    prod = {2'b00, r} * 8'd5 + 8'd1;
            2'd2:    prod = {2'b00, r} * 8'd3 + 8'd5;
            default: prod = {2'b00, r} * 8'd7;
        endcase
        return prod[WordIdxW-1:0];
    endfunction

endpackage

// File: src/md5_message_digest.sv
// MD5 message digest top level: byte intake, padding sequencer, chaining value.
// Depends on md5_pkg, md5_block_store and md5_round_unit.
//
//  channel  signals                                  direction
//  in       in_valid, in_stall, data_byte,           request in
//           byte_valid, last
//  out      out_valid, out_stall, digest_low,        request out
//           digest_high
//
// A byte request that fills the block starts a compression: load, 64 rounds of
// the shared round unit, chaining add.
// A last request then pads one byte per cycle, with one or two compressions,
// and ST_FIN moves the digest to the output register once the output is free.
// in_stall is high whenever the sequencer is busy; out_stall only delays the
// next digest hand-over. Reset is asynchronous and leaves the initial chain.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);
    import md5_pkg::*;

    md5_state_t        state_reg, state_next;
    logic [RoundW-1:0] rnd_reg, rnd_next;
    logic [LenW-1:0]   bit_len_reg, bit_len_next;
    logic [LenW-1:0]   msg_bits_reg, msg_bits_next;
    logic              fin_reg, fin_next;
    logic              sent80_reg, sent80_next;
    logic              len_phase_reg, len_phase_next;
    logic              final_blk_reg, final_blk_next;
    word_quad_t        chain_reg, chain_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       dig_lo_reg, dig_lo_next;
    logic [63:0]       dig_hi_reg, dig_hi_next;

    logic [PosW-1:0]     pos;
    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic [WordIdxW-1:0] rd_addr;
    logic [WordW-1:0]    msg_word;
    md5_rnd_ctl_t        rnd_ctl;
    word_quad_t          work;
    logic                out_free;

    assign pos = bit_len_reg[PosW+2:3];

    md5_block_store u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (pos),
        .wr_data (mem_wdata),
        .rd_addr (rd_addr),
        .rd_data (msg_word)
    );

    md5_round_unit u_round (
        .clk      (clk),
        .ctl      (rnd_ctl),
        .chain    (chain_reg),
        .msg_word (msg_word),
        .work     (work)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            bit_len_reg   <= '0;
            fin_reg       <= 1'b0;
            sent80_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            final_blk_reg <= 1'b0;
            chain_reg     <= MD5_IV;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            bit_len_reg   <= bit_len_next;
            fin_reg       <= fin_next;
            sent80_reg    <= sent80_next;
            len_phase_reg <= len_phase_next;
            final_blk_reg <= final_blk_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_bits_reg <= msg_bits_next;
        dig_lo_reg   <= dig_lo_next;
        dig_hi_reg   <= dig_hi_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        bit_len_next   = bit_len_reg;
        msg_bits_next  = msg_bits_reg;
        fin_next       = fin_reg;
        sent80_next    = sent80_reg;
        len_phase_next = len_phase_reg;
        final_blk_next = final_blk_reg;
        chain_next     = chain_reg;
        dig_lo_next    = dig_lo_reg;
        dig_hi_next    = dig_hi_reg;
        mem_we         = 1'b0;
        mem_wdata      = data_byte;
        rd_addr        = '0;
        rnd_ctl        = '{load: 1'b0, step: 1'b0, round: rnd_reg};

        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        mem_we       = 1'b1;
                        bit_len_next = bit_len_reg + LenW'(8);
                    end
                    if (last)
                    begin
                        fin_next       = 1'b1;
                        msg_bits_next  = bit_len_next;
                        sent80_next    = 1'b0;
                        len_phase_next = 1'b0;
                        final_blk_next = 1'b0;
                    end
                    if (byte_valid && pos == POS_LAST)
                    begin
                        state_next = ST_PREP;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                mem_we       = 1'b1;
                bit_len_next = bit_len_reg + LenW'(8);
                sent80_next  = 1'b1;
                if (!sent80_reg)
                begin
                    mem_wdata = PAD_MARK;
                end
                else if (len_phase_reg || pos == POS_LEN)
                begin
                    mem_wdata      = msg_bits_reg[{pos[2:0], 3'b000} +: 8];
                    len_phase_next = 1'b1;
                end
                else
                begin
                    mem_wdata = '0;
                end
                if (pos == POS_LAST)
                begin
                    final_blk_next = sent80_reg && len_phase_reg;
                    state_next     = ST_PREP;
                end
            end

            ST_PREP:
            begin
                rnd_ctl.load = 1'b1;
                rd_addr      = md5_word_idx('0);
                rnd_next     = '0;
                state_next   = ST_ROUND;
            end

            ST_ROUND:
            begin
                rnd_ctl.step = 1'b1;
                rd_addr      = md5_word_idx(rnd_reg + RoundW'(1));
                rnd_next     = rnd_reg + RoundW'(1);
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (final_blk_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (fin_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dig_lo_next    = {chain_reg[1], chain_reg[0]};
                    dig_hi_next    = {chain_reg[3], chain_reg[2]};
                    chain_next     = MD5_IV;
                    bit_len_next   = '0;
                    fin_next       = 1'b0;
                    final_blk_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digest_low  = dig_lo_reg;
    assign digest_high = dig_hi_reg;

endmodule

// File: src/md5_block_store.sv
// MD5 64-byte block store: byte-wide writes, registered word-wide reads.
// Depends on md5_pkg.
module md5_block_store (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [md5_pkg::PosW-1:0]          wr_addr,
    input  logic [7:0]                        wr_data,
    input  logic [md5_pkg::WordIdxW-1:0]      rd_addr,
    output logic [md5_pkg::WordW-1:0]         rd_data
);
    import md5_pkg::*;

    localparam int unsigned Words = 1 << WordIdxW;

    logic [WordW-1:0] mem [Words];
    logic [WordW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[PosW-1:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/md5_round_unit.sv
// MD5 round unit: working registers a to d and one round per step.
// Depends on md5_pkg.
module md5_round_unit (
    input  logic                      clk,
    input  md5_pkg::md5_rnd_ctl_t     ctl,
    input  md5_pkg::word_quad_t       chain,
    input  logic [md5_pkg::WordW-1:0] msg_word,
    output md5_pkg::word_quad_t       work
);
    import md5_pkg::*;

    logic [WordW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WordW-1:0] f;
    logic [WordW-1:0] t;
    logic [2*WordW-1:0] rot_wide;
    logic [WordW-1:0] b_next;

    always_comb
    begin
        case (ctl.round[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t        = a_reg + f + msg_word + md5_k(ctl.round);
        rot_wide = {t, t} << md5_rot(ctl.round);
        b_next   = b_reg + rot_wide[2*WordW-1:WordW];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg <= chain[0];
            b_reg <= chain[1];
            c_reg <= chain[2];
            d_reg <= chain[3];
        end
        else if (ctl.step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
        end
    end

    assign work = {d_reg, c_reg, b_reg, a_reg};

endmodule
